// ===== hdl/assert_macros.svh =====
// assertion macros shared by the rtl modules
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge out of reset
`define N2A_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("n2a assertion failed");

// condition must never be true out of reset
`define N2A_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("n2a forbidden condition seen");

`endif

// ===== hdl/n2a_pkg.sv =====
// shared types, constants and helper functions of the number to ascii converter
// no dependencies
package n2a_pkg;

  // format modes
  localparam logic [1:0] MODE_UDEC = 2'd0;
  localparam logic [1:0] MODE_SDEC = 2'd1;
  localparam logic [1:0] MODE_HEX  = 2'd2;
  localparam logic [1:0] MODE_BIN  = 2'd3;

  // ascii codes
  localparam logic [6:0] CH_ZERO  = 7'h30;
  localparam logic [6:0] CH_UPA   = 7'h41;
  localparam logic [6:0] CH_PLUS  = 7'h2B;
  localparam logic [6:0] CH_MINUS = 7'h2D;

  // per-mode digit limits
  localparam logic [5:0] CAP_DEC = 6'd10;
  localparam logic [5:0] CAP_HEX = 6'd8;
  localparam logic [5:0] CAP_BIN = 6'd32;

  // defaults for top level parameters
  localparam int MAX_DIGITS_DEF = 32;
  localparam int FIFO_DEPTH_DEF = 2;

  // one classified number travelling from front to back
  typedef struct packed {
    logic [1:0]  mode;
    logic        neg;
    logic [31:0] mag;
    logic [5:0]  cnt;
    logic [2:0]  line;
    logic [5:0]  col;
  } n2a_item_t;

  // digit limit of a mode
  function automatic logic [5:0] mode_cap(input logic [1:0] mode);
    logic [5:0] cap;
    case (mode)
      MODE_UDEC: cap = CAP_DEC;
      MODE_SDEC: cap = CAP_DEC;
      MODE_HEX:  cap = CAP_HEX;
      MODE_BIN:  cap = CAP_BIN;
      default:   cap = CAP_DEC;
    endcase
    return cap;
  endfunction

  // digit value to ascii
  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {3'b000, d};
    end else begin
      c = CH_UPA + {3'b000, d} - 7'd10;
    end
    return c;
  endfunction

endpackage

// ===== hdl/n2a_front.sv =====
// front end: classifies an incoming number (digit clamp, sign, magnitude)
// depends on n2a_pkg
module n2a_front #(
  parameter int MAX_DIGITS = n2a_pkg::MAX_DIGITS_DEF
) (
  input  logic [1:0]         action_i,
  input  logic [31:0]        value_i,
  input  logic [5:0]         digit_count_i,
  input  logic [2:0]         start_line_i,
  input  logic [4:0]         start_column_i,
  output n2a_pkg::n2a_item_t item_o
);
  import n2a_pkg::*;

  localparam logic [5:0] MaxD = 6'(MAX_DIGITS);

  logic [5:0] cap;
  logic [5:0] cnt_mode;
  logic       neg;

  // clamp the digit count to the mode limit and the build limit
  assign cap      = mode_cap(action_i);
  assign cnt_mode = (digit_count_i > cap) ? cap : digit_count_i;

  // signed mode shows the magnitude; the most negative value wraps to itself
  assign neg = (action_i == MODE_SDEC) && value_i[31];

  always_comb begin
    item_o.mode = action_i;
    item_o.neg  = neg;
    item_o.mag  = neg ? (32'd0 - value_i) : value_i;
    item_o.cnt  = (cnt_mode > MaxD) ? MaxD : cnt_mode;
    item_o.line = start_line_i;
    item_o.col  = {1'b0, start_column_i};
  end

endmodule

// ===== hdl/n2a_fifo.sv =====
// short queue between front and back, registers with a fill count
// depends on n2a_pkg and assert_macros.svh
module n2a_fifo #(
  parameter int DEPTH = n2a_pkg::FIFO_DEPTH_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  n2a_pkg::n2a_item_t wdata_i,
  input  logic               pop_i,
  output n2a_pkg::n2a_item_t rdata_o,
  output logic               full_o,
  output logic               empty_o
);
  import n2a_pkg::*;
  `include "assert_macros.svh"

  localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  n2a_item_t       mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;

  assign full_o  = (count_q == FullCnt);
  assign empty_o = (count_q == '0);
  assign rdata_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  `N2A_ASSERT(a_count_bound, count_q <= FullCnt)
  `N2A_NEVER(a_no_overflow, push_i && full_o)
  `N2A_NEVER(a_no_underflow, pop_i && empty_o)

endmodule

// ===== hdl/n2a_back.sv =====
// back end: splits the magnitude into digits, then sends ascii characters
// depends on n2a_pkg and assert_macros.svh
module n2a_back #(
  parameter int MAX_DIGITS = n2a_pkg::MAX_DIGITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  n2a_pkg::n2a_item_t item_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         line_o,
  output logic [5:0]         column_o,
  output logic [6:0]         char_code_o,
  output logic               last_o
);
  import n2a_pkg::*;
  `include "assert_macros.svh"

  localparam int DigW = 4 * MAX_DIGITS;
  localparam logic [5:0] MaxD = 6'(MAX_DIGITS);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SIGN = 2'd1;
  localparam logic [1:0] ST_CONV = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]      state_q, state_d;
  logic [1:0]      mode_q, mode_d;
  logic            neg_q, neg_d;
  logic [31:0]     val_q, val_d;
  logic [5:0]      cnt_q, cnt_d;
  logic [5:0]      ctr_q, ctr_d;
  logic [2:0]      line_q, line_d;
  logic [5:0]      col_q, col_d;
  logic [DigW-1:0] dig_q, dig_d;

  logic            out_valid_q;
  logic [2:0]      out_line_q;
  logic [5:0]      out_col_q;
  logic [6:0]      out_char_q;
  logic            out_last_q;

  logic            out_free;
  logic            out_load;
  logic [6:0]      out_char_d;
  logic            out_last_d;

  logic [63:0]     prod;
  logic [31:0]     q10;
  logic [31:0]     q10x10;
  logic [31:0]     r10;
  logic [3:0]      digit;
  logic [31:0]     val_next;

  // divide by ten through the reciprocal 0xCCCCCCCD, exact for 32-bit values
  assign prod   = {32'd0, val_q} * 64'h0000_0000_CCCC_CCCD;
  assign q10    = {3'b000, prod[63:35]};
  assign q10x10 = {q10[28:0], 3'b000} + {q10[30:0], 1'b0};
  assign r10    = val_q - q10x10;

  // low digit and remaining value per base
  always_comb begin
    case (mode_q)
      MODE_HEX: begin
        digit    = val_q[3:0];
        val_next = {4'h0, val_q[31:4]};
      end
      MODE_BIN: begin
        digit    = {3'b000, val_q[0]};
        val_next = {1'b0, val_q[31:1]};
      end
      default: begin
        digit    = r10[3:0];
        val_next = q10;
      end
    endcase
  end

  // output slot can take a character when empty or being drained
  assign out_free = !out_valid_q || !out_stall_i;

  // sequencer
  always_comb begin
    state_d    = state_q;
    mode_d     = mode_q;
    neg_d      = neg_q;
    val_d      = val_q;
    cnt_d      = cnt_q;
    ctr_d      = ctr_q;
    line_d     = line_q;
    col_d      = col_q;
    dig_d      = dig_q;
    pop_o      = 1'b0;
    out_load   = 1'b0;
    out_char_d = CH_ZERO;
    out_last_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o  = 1'b1;
          mode_d = item_i.mode;
          neg_d  = item_i.neg;
          val_d  = item_i.mag;
          cnt_d  = item_i.cnt;
          ctr_d  = item_i.cnt;
          line_d = item_i.line;
          col_d  = item_i.col;
          if (item_i.mode == MODE_SDEC) begin
            state_d = ST_SIGN;
          end else if (item_i.cnt != 6'd0) begin
            state_d = ST_CONV;
          end
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_char_d = neg_q ? CH_MINUS : CH_PLUS;
          out_last_d = (cnt_q == 6'd0);
          col_d      = col_q + 6'd1;
          state_d    = (cnt_q == 6'd0) ? ST_IDLE : ST_CONV;
        end
      end
      ST_CONV: begin
        // digits enter at the bottom, so the most significant ends up there
        dig_d = {dig_q[DigW-5:0], digit};
        val_d = val_next;
        ctr_d = ctr_q - 6'd1;
        if (ctr_q == 6'd1) begin
          ctr_d   = cnt_q;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_char_d = digit_char(dig_q[3:0]);
          out_last_d = (ctr_q == 6'd1);
          dig_d      = {4'h0, dig_q[DigW-1:4]};
          col_d      = col_q + 6'd1;
          ctr_d      = ctr_q - 6'd1;
          if (ctr_q == 6'd1) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ctr_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ctr_q   <= ctr_d;
      cnt_q   <= cnt_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working payload
  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    neg_q  <= neg_d;
    val_q  <= val_d;
    line_q <= line_d;
    col_q  <= col_d;
    dig_q  <= dig_d;
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_line_q <= line_q;
      out_col_q  <= col_q;
      out_char_q <= out_char_d;
      out_last_q <= out_last_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign line_o      = out_line_q;
  assign column_o    = out_col_q;
  assign char_code_o = out_char_q;
  assign last_o      = out_last_q;

  `N2A_NEVER(a_ctr_live, (state_q == ST_CONV || state_q == ST_EMIT) && ctr_q == 6'd0)
  `N2A_NEVER(a_cnt_fits, state_q != ST_IDLE && cnt_q > MaxD)
  `N2A_ASSERT(a_last_ends, (state_q == ST_EMIT && out_load && ctr_q == 6'd1) |=> state_q == ST_IDLE)

endmodule

// ===== hdl/number_to_ascii_digits_top.sv =====
// An accepted number is written into the queue; the back end pops it once the queue shows
// it, sends the sign first in signed mode, then splits the digits and sends them.
// The back end works on one number at a time, taking one digit per cycle out of the
// magnitude and then sending one character per cycle while the output is not stalled.
// Reset clears all control state and the queue; no storage is swept.
// top level: front classifier, queue and digit back end
// depends on n2a_pkg, n2a_front, n2a_fifo and n2a_back
module number_to_ascii_digits_top #(
  parameter int MAX_DIGITS = n2a_pkg::MAX_DIGITS_DEF,
  parameter int FIFO_DEPTH = n2a_pkg::FIFO_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  action_i,
  input  logic [31:0] value_i,
  input  logic [5:0]  digit_count_i,
  input  logic [2:0]  start_line_i,
  input  logic [4:0]  start_column_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  line_o,
  output logic [5:0]  column_o,
  output logic [6:0]  char_code_o,
  output logic        last_o
);
  import n2a_pkg::*;

  n2a_item_t front_item;
  n2a_item_t queue_item;
  logic      q_full;
  logic      q_empty;
  logic      q_push;
  logic      q_pop;

  assign in_stall_o = q_full;
  assign q_push     = in_valid_i && !q_full;

  n2a_front #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_front (
    .action_i      (action_i),
    .value_i       (value_i),
    .digit_count_i (digit_count_i),
    .start_line_i  (start_line_i),
    .start_column_i(start_column_i),
    .item_o        (front_item)
  );

  n2a_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .wdata_i(front_item),
    .pop_i  (q_pop),
    .rdata_o(queue_item),
    .full_o (q_full),
    .empty_o(q_empty)
  );

  n2a_back #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .empty_i    (q_empty),
    .item_i     (queue_item),
    .pop_o      (q_pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .line_o     (line_o),
    .column_o   (column_o),
    .char_code_o(char_code_o),
    .last_o     (last_o)
  );

endmodule

// ===== tb/sv/number_to_ascii_digits_checker.sv =====
// checker for the number to ascii converter: watches both channels, predicts the characters
// of every accepted number and compares each delivered character against them
// depends on n2a_pkg
module number_to_ascii_digits_checker #(
  parameter int MAX_DIGITS = n2a_pkg::MAX_DIGITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [1:0]  action_i,
  input  logic [31:0] value_i,
  input  logic [5:0]  digit_count_i,
  input  logic [2:0]  start_line_i,
  input  logic [4:0]  start_column_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  line_i,
  input  logic [5:0]  column_i,
  input  logic [6:0]  char_code_i,
  input  logic        last_i,
  output int          mismatch_count_o = 0,
  output int          pending_chars_o = 0
);
  timeunit 1ns;
  timeprecision 1ps;
  import n2a_pkg::*;

  // one character word on the output channel
  typedef struct packed {
    logic [2:0] line;
    logic [5:0] column;
    logic [6:0] code;
    logic       last;
  } text_char_t;

  text_char_t expected_chars[$];

  // turn one number into the characters the block should send, oldest first
  task automatic render_number(input logic [1:0] mode, input logic [31:0] num,
                               input logic [5:0] count, input logic [2:0] ln,
                               input logic [4:0] col0);
    logic [5:0]  ndig;
    logic [5:0]  limit;
    logic [31:0] radix;
    logic [31:0] mag;
    logic [5:0]  col;
    logic [3:0]  digs [32];
    logic [3:0]  d;
    text_char_t  c;
    case (mode)
      MODE_HEX: limit = CAP_HEX;
      MODE_BIN: limit = CAP_BIN;
      default:  limit = CAP_DEC;
    endcase
    ndig = (count > limit) ? limit : count;
    if (ndig > MAX_DIGITS) ndig = 6'(MAX_DIGITS);
    radix = (mode == MODE_HEX) ? 32'd16 : (mode == MODE_BIN) ? 32'd2 : 32'd10;
    mag = num;
    col = {1'b0, col0};
    // signed mode leads with the sign and shows the magnitude
    if (mode == MODE_SDEC) begin
      c.line = ln;
      c.column = col;
      c.code = num[31] ? CH_MINUS : CH_PLUS;
      c.last = (ndig == 6'd0);
      expected_chars.push_back(c);
      col = col + 6'd1;
      if (num[31]) mag = 32'd0 - num;
    end
    // low digits first, higher ones are dropped
    for (int k = 0; k < ndig; k++) begin
      digs[k] = 4'(mag % radix);
      mag = mag / radix;
    end
    for (int k = 0; k < ndig; k++) begin
      d = digs[ndig - 1 - k];
      c.line = ln;
      c.column = col + 6'(k);
      c.code = (d < 4'd10) ? CH_ZERO + {3'b000, d} : CH_UPA + {3'b000, d} - 7'd10;
      c.last = (k == ndig - 1);
      expected_chars.push_back(c);
    end
  endtask

  // predict on accepted numbers, then compare accepted characters
  always @(posedge clk_i or negedge rst_ni) begin
    text_char_t want;
    if (!rst_ni) begin
      expected_chars.delete();
    end else begin
      if (in_valid_i && !in_stall_i) begin
        render_number(action_i, value_i, digit_count_i, start_line_i, start_column_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected char line=%0d col=%0d code=%h last=%b", $time,
                   line_i, column_i, char_code_i, last_i);
          mismatch_count_o++;
        end else begin
          want = expected_chars.pop_front();
          if (line_i !== want.line) begin
            $display("%0t: line expected %0d actual %0d", $time, want.line, line_i);
            mismatch_count_o++;
          end
          if (column_i !== want.column) begin
            $display("%0t: column expected %0d actual %0d", $time, want.column, column_i);
            mismatch_count_o++;
          end
          if (char_code_i !== want.code) begin
            $display("%0t: char expected %h actual %h", $time, want.code, char_code_i);
            mismatch_count_o++;
          end
          if (last_i !== want.last) begin
            $display("%0t: last expected %b actual %b", $time, want.last, last_i);
            mismatch_count_o++;
          end
        end
      end
    end
    pending_chars_o = expected_chars.size();
  end

endmodule

// ===== tb/sv/number_to_ascii_digits_top_tb.sv =====
// testbench top for the number to ascii converter: drives numbers and output stalls
// and gives the verdict from the checker's mismatch count
// depends on n2a_pkg, number_to_ascii_digits_top and number_to_ascii_digits_checker
module number_to_ascii_digits_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import n2a_pkg::*;

  localparam int MAX_DIGITS    = n2a_pkg::MAX_DIGITS_DEF;
  localparam int RANDOM_WORDS  = 420;
  localparam int QUIET_FROM    = 360;
  localparam int HOLD_AT       = 100;
  localparam int HOLD_CYCLES   = 200;
  localparam int TAIL_CYCLES   = 100;
  localparam int CYCLE_LIMIT   = 400000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  action = MODE_UDEC;
  logic [31:0] value = '0;
  logic [5:0]  digit_count = '0;
  logic [2:0]  start_line = '0;
  logic [4:0]  start_column = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  line;
  logic [5:0]  column;
  logic [6:0]  char_code;
  logic        last;

  int mismatch_count;
  int pending_chars;
  int cycle_count = 0;
  bit quiet = 1'b0;
  bit hold_request = 1'b0;

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  number_to_ascii_digits_top #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .action_i       (action),
    .value_i        (value),
    .digit_count_i  (digit_count),
    .start_line_i   (start_line),
    .start_column_i (start_column),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .line_o         (line),
    .column_o       (column),
    .char_code_o    (char_code),
    .last_o         (last)
  );

  number_to_ascii_digits_checker #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .action_i         (action),
    .value_i          (value),
    .digit_count_i    (digit_count),
    .start_line_i     (start_line),
    .start_column_i   (start_column),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .line_i           (line),
    .column_i         (column),
    .char_code_i      (char_code),
    .last_i           (last),
    .mismatch_count_o (mismatch_count),
    .pending_chars_o  (pending_chars)
  );

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // offer one number word and wait until it is taken
  task automatic send_number(input logic [1:0] mode, input logic [31:0] num,
                             input logic [5:0] count, input logic [2:0] ln,
                             input logic [4:0] col);
    action <= mode;
    value <= num;
    digit_count <= count;
    start_line <= ln;
    start_column <= col;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // drop valid for a while, with junk on the payload
  task automatic sender_gap(input int cycles);
    in_valid <= 1'b0;
    action <= 2'($urandom);
    value <= $urandom;
    digit_count <= 6'($urandom);
    start_line <= 3'($urandom);
    start_column <= 5'($urandom);
    repeat (cycles) @(posedge clk);
  endtask

  // mix of edge values, small values and plain random bits
  function automatic logic [31:0] pick_value();
    logic [31:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 999);
      1: v = 32'd0 - 32'($urandom_range(0, 999));
      2: begin
        case ($urandom_range(0, 3))
          0: v = 32'h8000_0000;
          1: v = 32'hFFFF_FFFF;
          2: v = 32'h7FFF_FFFF;
          default: v = 32'h0;
        endcase
      end
      3: v = $urandom >> $urandom_range(0, 31);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // mostly short numbers, some zero and some past every limit
  function automatic logic [5:0] pick_count();
    logic [5:0] n;
    case ($urandom_range(0, 9))
      0: n = 6'd0;
      1, 2: n = 6'($urandom_range(0, 63));
      default: n = 6'($urandom_range(1, 10));
    endcase
    return n;
  endfunction

  // receiver: random stall bursts, calm stretches and one long hold-off
  initial begin
    int calm;
    calm = 0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
        hold_request = 1'b0;
      end else if (quiet) begin
        calm = 0;
      end else if (calm > 0) begin
        calm--;
      end else if ($urandom_range(0, 15) == 0) begin
        calm = $urandom_range(20, 80);
      end else if ($urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 7)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // reset, directed numbers, random numbers, drain and verdict
  initial begin
    int calm;
    calm = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // unsigned decimal: zero, full scale, clamp, no digits, high digits dropped
    send_number(MODE_UDEC, 32'h0, 6'd10, 3'd1, 5'd1);
    send_number(MODE_UDEC, 32'hFFFF_FFFF, 6'd10, 3'd4, 5'd16);
    send_number(MODE_UDEC, 32'hFFFF_FFFF, 6'd63, 3'd7, 5'd31);
    send_number(MODE_UDEC, 32'd12345, 6'd0, 3'd2, 5'd3);
    send_number(MODE_UDEC, 32'd123456, 6'd3, 3'd0, 5'd0);
    // signed decimal: most negative, most positive, sign only, small values
    send_number(MODE_SDEC, 32'h8000_0000, 6'd10, 3'd1, 5'd1);
    send_number(MODE_SDEC, 32'h7FFF_FFFF, 6'd63, 3'd3, 5'd31);
    send_number(MODE_SDEC, 32'hFFFF_FFFF, 6'd0, 3'd5, 5'd7);
    send_number(MODE_SDEC, 32'h0, 6'd0, 3'd6, 5'd8);
    send_number(MODE_SDEC, 32'hFFFF_FFFF, 6'd3, 3'd2, 5'd2);
    send_number(MODE_SDEC, 32'h0, 6'd1, 3'd4, 5'd16);
    // hexadecimal: letters, clamp, single digit, no digits
    send_number(MODE_HEX, 32'hDEAD_BEEF, 6'd8, 3'd1, 5'd1);
    send_number(MODE_HEX, 32'hFFFF_FFFF, 6'd63, 3'd7, 5'd31);
    send_number(MODE_HEX, 32'h0123_4567, 6'd8, 3'd0, 5'd0);
    send_number(MODE_HEX, 32'hABCD_EF09, 6'd1, 3'd2, 5'd5);
    send_number(MODE_HEX, 32'hFFFF_FFFF, 6'd0, 3'd3, 5'd9);
    // binary: full width, clamp, short, no digits
    send_number(MODE_BIN, 32'hA5A5_A5A5, 6'd32, 3'd1, 5'd31);
    send_number(MODE_BIN, 32'hFFFF_FFFF, 6'd63, 3'd7, 5'd16);
    send_number(MODE_BIN, 32'h1, 6'd5, 3'd4, 5'd0);
    send_number(MODE_BIN, 32'h5A5A_5A5A, 6'd0, 3'd0, 5'd1);
    send_number(MODE_BIN, 32'h0, 6'd32, 3'd6, 5'd15);

    // random numbers
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == HOLD_AT) hold_request = 1'b1;
      if (i == QUIET_FROM) quiet = 1'b1;
      send_number(2'($urandom), pick_value(), pick_count(), 3'($urandom),
                  5'($urandom));
      if (!quiet) begin
        if (calm > 0) begin
          calm--;
        end else if ($urandom_range(0, 9) == 0) begin
          calm = $urandom_range(10, 30);
        end else if ($urandom_range(0, 2) == 0) begin
          sender_gap($urandom_range(1, 7));
        end
      end
    end
    in_valid <= 1'b0;

    // drain
    @(posedge clk);
    while (pending_chars != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/n2a_pkg.sv
hdl/n2a_front.sv
hdl/n2a_fifo.sv
hdl/n2a_back.sv
hdl/number_to_ascii_digits_top.sv
tb/sv/number_to_ascii_digits_checker.sv
tb/sv/number_to_ascii_digits_top_tb.sv
